>>> sv/ntw_pkg.sv
package ntw_pkg;

    localparam int unsigned SLOTS = 6;

    typedef logic [4:0] word_t;

    localparam word_t WORD_ZERO     = 5'd0;
    localparam word_t TENS_BASE     = 5'd18;
    localparam word_t WORD_HUNDRED  = 5'd28;
    localparam word_t WORD_THOUSAND = 5'd29;

    // Token positions in an entry, in spoken order.
    localparam int unsigned SLOT_THOU      = 0;
    localparam int unsigned SLOT_THOU_WORD = 1;
    localparam int unsigned SLOT_HUND      = 2;
    localparam int unsigned SLOT_HUND_WORD = 3;
    localparam int unsigned SLOT_TAIL_HI   = 4;
    localparam int unsigned SLOT_TAIL_LO   = 5;

    typedef struct packed {
        logic [SLOTS-1:0]       present;
        word_t [SLOTS-1:0]      words;
    } entry_t;

endpackage

>>> sv/ntw_front.sv
module ntw_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [13:0]       s_value,
    output logic              q_push_valid,
    output ntw_pkg::entry_t   q_push_entry,
    input  logic              q_push_ready
);

    logic        a_valid_reg, a_valid_next;
    logic [13:0] a_value_reg, a_value_next;
    logic        b_valid_reg, b_valid_next;
    logic [4:0]  b_thou_reg, b_thou_next;
    logic [9:0]  b_rem_reg, b_rem_next;
    logic        c_valid_reg, c_valid_next;
    logic [4:0]  c_thou_reg, c_thou_next;
    logic [3:0]  c_hund_reg, c_hund_next;
    logic [6:0]  c_low2_reg, c_low2_next;

    logic        a_take, a_adv, b_take, b_adv, c_take, c_adv;
    logic [4:0]  thou;
    logic [3:0]  hund;
    logic [3:0]  ten;
    logic [3:0]  one;
    logic        is_zero;
    ntw_pkg::entry_t entry;

    assign c_adv  = c_valid_reg && q_push_ready;
    assign c_take = !c_valid_reg || c_adv;
    assign b_adv  = b_valid_reg && c_take;
    assign b_take = !b_valid_reg || b_adv;
    assign a_adv  = a_valid_reg && b_take;
    assign a_take = !a_valid_reg || a_adv;
    assign s_ready = a_take;

    // The thousands count is found by comparing against every multiple of 1000.
    always_comb begin
        thou = '0;
        for (int k = 1; k <= 16; k++) begin
            if (a_value_reg >= 14'(k * 1000)) begin
                thou = 5'(k);
            end
        end
    end

    always_comb begin
        hund = '0;
        for (int k = 1; k <= 9; k++) begin
            if (b_rem_reg >= 10'(k * 100)) begin
                hund = 4'(k);
            end
        end
    end

    always_comb begin
        ten = '0;
        for (int k = 1; k <= 9; k++) begin
            if (c_low2_reg >= 7'(k * 10)) begin
                ten = 4'(k);
            end
        end
        one = 4'(c_low2_reg - 7'(ten) * 7'd10);
    end

    always_comb begin
        is_zero = (c_thou_reg == '0) && (c_hund_reg == '0) && (c_low2_reg == '0);
        entry = '0;
        entry.words[ntw_pkg::SLOT_THOU]        = c_thou_reg;
        entry.present[ntw_pkg::SLOT_THOU]      = (c_thou_reg != '0);
        entry.words[ntw_pkg::SLOT_THOU_WORD]   = ntw_pkg::WORD_THOUSAND;
        entry.present[ntw_pkg::SLOT_THOU_WORD] = (c_thou_reg != '0);
        entry.words[ntw_pkg::SLOT_HUND]        = {1'b0, c_hund_reg};
        entry.present[ntw_pkg::SLOT_HUND]      = (c_hund_reg != '0);
        entry.words[ntw_pkg::SLOT_HUND_WORD]   = ntw_pkg::WORD_HUNDRED;
        entry.present[ntw_pkg::SLOT_HUND_WORD] = (c_hund_reg != '0);
        if (is_zero) begin
            entry.words[ntw_pkg::SLOT_TAIL_HI]   = ntw_pkg::WORD_ZERO;
            entry.present[ntw_pkg::SLOT_TAIL_HI] = 1'b1;
        end else if ((c_low2_reg != '0) && (c_low2_reg < 7'd20)) begin
            entry.words[ntw_pkg::SLOT_TAIL_HI]   = 5'(c_low2_reg);
            entry.present[ntw_pkg::SLOT_TAIL_HI] = 1'b1;
        end else begin
            entry.words[ntw_pkg::SLOT_TAIL_HI]   = ntw_pkg::TENS_BASE + {1'b0, ten};
            entry.present[ntw_pkg::SLOT_TAIL_HI] = (ten != '0);
            entry.words[ntw_pkg::SLOT_TAIL_LO]   = {1'b0, one};
            entry.present[ntw_pkg::SLOT_TAIL_LO] = (one != '0);
        end
    end

    assign q_push_valid = c_valid_reg;
    assign q_push_entry = entry;

    always_comb begin
        a_valid_next = a_take ? s_valid : a_valid_reg;
        a_value_next = (a_take && s_valid) ? s_value : a_value_reg;
        b_valid_next = b_take ? a_valid_reg : b_valid_reg;
        b_thou_next  = a_adv ? thou : b_thou_reg;
        b_rem_next   = a_adv ? 10'(a_value_reg - 14'(thou) * 14'd1000) : b_rem_reg;
        c_valid_next = c_take ? b_valid_reg : c_valid_reg;
        c_thou_next  = b_adv ? b_thou_reg : c_thou_reg;
        c_hund_next  = b_adv ? hund : c_hund_reg;
        c_low2_next  = b_adv ? 7'(b_rem_reg - 10'(hund) * 10'd100) : c_low2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_value_reg <= a_value_next;
        b_thou_reg  <= b_thou_next;
        b_rem_reg   <= b_rem_next;
        c_thou_reg  <= c_thou_next;
        c_hund_reg  <= c_hund_next;
        c_low2_reg  <= c_low2_next;
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> (b_rem_reg < 10'd1000) && (b_thou_reg <= 5'd16))
        else $error("ntw_front: thousands split out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg |-> (c_low2_reg < 7'd100) && (c_hund_reg <= 4'd9))
        else $error("ntw_front: hundreds split out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg |-> (entry.present != '0)
            && (entry.present[ntw_pkg::SLOT_THOU] == entry.present[ntw_pkg::SLOT_THOU_WORD])
            && (entry.present[ntw_pkg::SLOT_HUND] == entry.present[ntw_pkg::SLOT_HUND_WORD]))
        else $error("ntw_front: malformed token entry");
`endif

endmodule

>>> sv/ntw_queue.sv
module ntw_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  ntw_pkg::entry_t   push_entry,
    output logic              pop_valid,
    input  logic              pop_ready,
    output ntw_pkg::entry_t   pop_entry
);

    ntw_pkg::entry_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> sv/ntw_back.sv
module ntw_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  ntw_pkg::entry_t   q_entry,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [4:0]        m_word,
    output logic              m_last
);

    logic [ntw_pkg::SLOTS-1:0] pend_reg, pend_next;
    ntw_pkg::word_t [ntw_pkg::SLOTS-1:0] words_reg, words_next;
    logic        m_valid_reg, m_valid_next;
    logic [4:0]  m_word_reg, m_word_next;
    logic        m_last_reg, m_last_next;

    logic [ntw_pkg::SLOTS-1:0] low_bit, rest;
    logic        have, out_free, load_out, entry_free;
    ntw_pkg::word_t word_sel;

    assign have     = (pend_reg != '0);
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = have && out_free;
    assign low_bit  = pend_reg & (~pend_reg + 1'b1);
    assign rest     = pend_reg & ~low_bit;
    assign entry_free = !have || (load_out && (rest == '0));
    assign q_ready  = entry_free;

    always_comb begin
        word_sel = '0;
        for (int i = 0; i < ntw_pkg::SLOTS; i++) begin
            word_sel = word_sel | (words_reg[i] & {5{low_bit[i]}});
        end
    end

    always_comb begin
        pend_next   = pend_reg;
        words_next  = words_reg;
        m_valid_next = m_valid_reg;
        m_word_next = m_word_reg;
        m_last_next = m_last_reg;
        if (load_out) begin
            pend_next    = rest;
            m_valid_next = 1'b1;
            m_word_next  = word_sel;
            m_last_next  = (rest == '0);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (entry_free && q_valid) begin
            pend_next  = q_entry.present;
            words_next = q_entry.words;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        words_reg  <= words_next;
        m_word_reg <= m_word_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;
    assign m_last  = m_last_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_word_reg <= ntw_pkg::WORD_THOUSAND))
        else $error("ntw_back: word code out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> (pend_reg != '0))
        else $error("ntw_back: non-final beat without remaining tokens");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (have && out_free) |=> m_valid_reg)
        else $error("ntw_back: pending token not presented");
`endif

endmodule

>>> sv/number_to_word_tokens_unit.sv
// Spells a number as a run of English word tokens: digit or teen words 0-19, tens words
// twenty to ninety as 20-27, hundred as 28 and thousand as 29, one token per output beat,
// with m_last set on the final beat of each number; zero gives the single token zero.
// Values above 9999 spell the thousands count 10-16 with its teen word. A number makes
// one to six beats, and the output side moves one beat per cycle while m_ready is high.
// The input side takes a number every cycle into a three-stage digit split and a
// two-entry queue, and it only stalls when the queue and split stages are full behind
// the token sequencer.
module number_to_word_tokens_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [13:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_word,
    output logic        m_last
);

    logic            push_valid, push_ready;
    ntw_pkg::entry_t push_entry;
    logic            pop_valid, pop_ready;
    ntw_pkg::entry_t pop_entry;

    ntw_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .q_push_valid (push_valid),
        .q_push_entry (push_entry),
        .q_push_ready (push_ready)
    );

    ntw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    ntw_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (pop_valid),
        .q_ready (pop_ready),
        .q_entry (pop_entry),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word),
        .m_last  (m_last)
    );

endmodule
